// ----- rtl/vms_pkg.sv -----
// Shared types and constants for the vertex magnitude sorter.
`default_nettype none
package vms_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 24;
  localparam int SQ_W         = 2 * COORD_W;

  localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] magnitude;
    logic               last_result;
    logic               overflowed;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/vertex_magnitude_sorter_top.sv -----
// Vertex magnitude sorter: iterative root, memory-held insertion sort, sorted drain.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------
//  in_      | input     | in_valid / in_ready | in_beat_t
//  out_     | output    | out_valid/out_ready | out_beat_t
//
// One vertex passes through squares, add, 24 root steps and a final write, plus a read
// and a compare per stored entry it moves past in the insertion walk, one more pair when
// the walk stops on a smaller or equal entry; a vertex that finds the store full is dropped.
// A last vertex then drains the store, reading each beat only once the previous one is taken.
// Reset is synchronous; the store holds no reset value and needs no clearing pass.
// Output stalls hold the drain; the last beat may wait while the next vertex is taken.
`default_nettype none
module vertex_magnitude_sorter_top
  import vms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  logic [COORD_W-1:0] mem [MAX_VERTICES];
  logic [COORD_W-1:0] rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [COORD_W-1:0] mem_wdata;

  state_t             state_r, state_nxt;
  logic [COORD_W-1:0] ax_r, ax_nxt;
  logic [COORD_W-1:0] ay_r, ay_nxt;
  logic [SQ_W-1:0]    prod_r, prod_nxt;
  logic [SQ_W-1:0]    rem_r, rem_nxt;
  logic [SQ_W-1:0]    res_r, res_nxt;
  logic [SQ_W-1:0]    bit_r, bit_nxt;
  logic               last_r, last_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               drop_r, drop_nxt;
  out_beat_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [COORD_W-1:0] mul_in;
  logic [SQ_W-1:0]    mul_out;
  logic [SQ_W-1:0]    trial;
  logic               full;
  logic               run_end;
  state_t             after_ins;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign mul_in  = (state_r == ST_SQX) ? ax_r : ay_r;
  assign mul_out = SQ_W'(mul_in) * SQ_W'(mul_in);
  assign trial   = res_r + bit_r;
  assign full    = (count_r == CNT_W'(MAX_VERTICES));
  assign run_end = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = res_r[COORD_W-1:0];
    mem_raddr     = pos_r - ADDR_W'(1);
    after_ins     = last_r ? ST_EMIT_RD : ST_IDLE;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ax_nxt    = in_data.x_coord[COORD_W-1] ? (~in_data.x_coord + COORD_W'(1))
                                                 : in_data.x_coord;
          ay_nxt    = in_data.y_coord[COORD_W-1] ? (~in_data.y_coord + COORD_W'(1))
                                                 : in_data.y_coord;
          last_nxt  = in_data.last_vertex;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        rem_nxt   = mul_out;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        prod_nxt  = mul_out;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        rem_nxt   = rem_r + prod_r;
        res_nxt   = '0;
        bit_nxt   = ROOT_BIT_INIT;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          idx_nxt = '0;
          if (full) begin
            drop_nxt  = 1'b1;
            state_nxt = after_ins;
          end else begin
            pos_nxt   = count_r[ADDR_W-1:0];
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = after_ins;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_r > res_r[COORD_W-1:0]) begin
          mem_wdata = rdata_r;
          pos_nxt   = pos_r - ADDR_W'(1);
          state_nxt = ST_INS_RD;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = after_ins;
        end
      end
      ST_EMIT_RD: begin
        mem_raddr = idx_r;
        if (!out_valid_r) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_nxt.magnitude   = rdata_r;
        out_nxt.last_result = run_end;
        out_nxt.overflowed  = drop_r;
        out_valid_nxt       = 1'b1;
        if (run_end) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    last_r <= last_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
